// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the validator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GBV_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define GBV_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define GBV_ASSERT(lbl, clk, rst_n, prop)
`define GBV_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- hdl/gbv_pkg.sv -----
// Types, phase codes and byte-class functions for the GB18030 validator.
`default_nettype none
package gbv_pkg;

	typedef enum logic [1:0] {
		PH_LEAD   = 2'd0,
		PH_TRAIL  = 2'd1,
		PH_THIRD  = 2'd2,
		PH_FOURTH = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
	} word_t;

	typedef struct packed {
		phase_t phase;
		logic   failed;
	} chk_status_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic trail_ok(input logic [7:0] lead, input logic [7:0] b);
		logic low_fe;
		logic low_a0;
		logic low_ef;
		logic special;
		low_fe  = (b >= 8'h40) && (b <= 8'hFE) && (b != 8'h7F);
		low_a0  = (b >= 8'h40) && (b <= 8'hA0) && (b != 8'h7F);
		low_ef  = (b >= 8'h40) && (b <= 8'hEF) && (b != 8'h7F);
		special = ((lead == 8'hA2) && (b == 8'hE3)) ||
			((lead == 8'hA6) && (b >= 8'hD9) && (b <= 8'hDF)) ||
			((lead == 8'hA6) && (b == 8'hF3));
		priority if (lead < 8'hA1) begin
			return low_fe;
		end else if (lead < 8'hA8) begin
			return special || ((b >= 8'hA1) && (b <= 8'hFE));
		end else if (lead < 8'hAA) begin
			return special || low_ef;
		end else if (lead < 8'hB0) begin
			return low_a0;
		end else if (lead < 8'hF8) begin
			return low_fe;
		end else begin
			return low_a0;
		end
	endfunction

	function automatic logic four_lead_ok(input logic [7:0] lead);
		return ((lead >= 8'h81) && (lead <= 8'h84)) ||
			((lead >= 8'h90) && (lead <= 8'hE3));
	endfunction

endpackage
`default_nettype wire

// ----- hdl/gbv_byte_if.sv -----
// Byte input channel: one text byte and its end marker per word.
`default_nettype none
interface gbv_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_last;

	modport source (output valid, output data_byte, output is_last, input ready);
	modport sink (input valid, input data_byte, input is_last, output ready);
endinterface
`default_nettype wire

// ----- hdl/gbv_result_if.sv -----
// Verdict output channel: one validity flag per string.
`default_nettype none
interface gbv_result_if;
	logic valid;
	logic ready;
	logic is_valid;

	modport source (output valid, output is_valid, input ready);
	modport sink (input valid, input is_valid, output ready);
endinterface
`default_nettype wire

// ----- hdl/gbv_in_reg.sv -----
// Input register stage holding one accepted byte word.
`default_nettype none
module gbv_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic                advance,
	input  gbv_pkg::word_t      word_in,
	output logic                valid_s1,
	output gbv_pkg::word_t      word_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_s1 <= word_in;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/gbv_check.sv -----
// Per-string decode state and verdict logic.
`default_nettype none
module gbv_check (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  gbv_pkg::word_t        word_s1,
	output logic                  verdict,
	output gbv_pkg::chk_status_t  status
);

	gbv_pkg::phase_t phase_q, phase_d;
	logic [7:0]      lead_q, lead_d;
	logic            failed_q, failed_d;
	logic [7:0]      b;

	assign b = word_s1.data_byte;

	always_comb begin
		phase_d  = phase_q;
		lead_d   = lead_q;
		failed_d = failed_q;
		if (!failed_q) begin
			unique case (phase_q)
				gbv_pkg::PH_LEAD: begin
					if (b[7]) begin
						if ((b == 8'h80) || (b == 8'hFF)) begin
							failed_d = 1'b1;
						end else begin
							lead_d  = b;
							phase_d = gbv_pkg::PH_TRAIL;
						end
					end
				end
				gbv_pkg::PH_TRAIL: begin
					if (gbv_pkg::is_digit(b)) begin
						phase_d = gbv_pkg::PH_THIRD;
					end else begin
						failed_d = !gbv_pkg::trail_ok(lead_q, b);
						phase_d  = gbv_pkg::PH_LEAD;
					end
				end
				gbv_pkg::PH_THIRD: begin
					failed_d = (b < 8'h81) || (b > 8'hFE);
					phase_d  = gbv_pkg::PH_FOURTH;
				end
				gbv_pkg::PH_FOURTH: begin
					failed_d = !gbv_pkg::is_digit(b) || !gbv_pkg::four_lead_ok(lead_q);
					phase_d  = gbv_pkg::PH_LEAD;
				end
				default: begin
					phase_d = gbv_pkg::PH_LEAD;
				end
			endcase
		end
		verdict = !failed_d &&
			((phase_d == gbv_pkg::PH_LEAD) || (phase_d == gbv_pkg::PH_TRAIL));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= gbv_pkg::PH_LEAD;
			lead_q   <= 8'h00;
			failed_q <= 1'b0;
		end else if (advance) begin
			if (word_s1.is_last) begin
				phase_q  <= gbv_pkg::PH_LEAD;
				lead_q   <= 8'h00;
				failed_q <= 1'b0;
			end else begin
				phase_q  <= phase_d;
				lead_q   <= lead_d;
				failed_q <= failed_d;
			end
		end
	end

	assign status.phase  = phase_q;
	assign status.failed = failed_q;

endmodule
`default_nettype wire

// ----- hdl/gbv_out_reg.sv -----
// Result register for the end-of-string verdict.
`default_nettype none
module gbv_out_reg (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  logic verdict,
	input  logic take,
	output logic valid_q,
	output logic verdict_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			verdict_q <= verdict;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/gb18030_stream_validator.sv -----
// Top level of the GB18030 stream validator.
//
//   channel   dir  payload               word meaning
//   in_ch     in   data_byte, is_last    one text byte, end-of-string mark
//   out_ch    out  is_valid              verdict for the finished string
//
// One byte word per cycle unless stalled; out_ch.valid comes from the result register.
// Bytes pass through an input register, then the decode logic updates the
// per-string state; only last bytes load the result register.
// A waiting verdict holds the next last byte in the input register, and the
// input stalls until the verdict is taken; other bytes pass freely.
// Reset clears the decode state; every string starts fresh after its last byte.
`default_nettype none
`include "assert_macros.svh"
module gb18030_stream_validator (
	input  logic                clk,
	input  logic                arst_n,
	gbv_byte_if.sink            in_ch,
	gbv_result_if.source        out_ch
);

	logic                  valid_s1;
	gbv_pkg::word_t        word_s1;
	gbv_pkg::word_t        word_in;
	logic                  advance;
	logic                  load_in;
	logic                  verdict;
	logic                  out_valid;
	logic                  out_verdict;
	gbv_pkg::chk_status_t  status;

	assign advance = valid_s1 && (!word_s1.is_last || !out_valid || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign load_in = in_ch.valid && in_ch.ready;

	assign word_in.data_byte = in_ch.data_byte;
	assign word_in.is_last   = in_ch.is_last;

	gbv_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load_in),
		.advance  (advance),
		.word_in  (word_in),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	gbv_check u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.word_s1 (word_s1),
		.verdict (verdict),
		.status  (status)
	);

	gbv_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && word_s1.is_last),
		.verdict   (verdict),
		.take      (out_ch.ready),
		.valid_q   (out_valid),
		.verdict_q (out_verdict)
	);

	assign out_ch.valid    = out_valid;
	assign out_ch.is_valid = out_verdict;

	`GBV_ASSERT(a_verdict_from_last, clk, arst_n, $rose(out_valid) |-> $past(advance && word_s1.is_last))
	`GBV_ASSERT(a_state_clear_after_last, clk, arst_n, (advance && word_s1.is_last) |=> (status.phase == gbv_pkg::PH_LEAD && !status.failed))
	`GBV_ASSERT(a_last_held_on_stall, clk, arst_n, (valid_s1 && word_s1.is_last && out_valid && !out_ch.ready) |=> (valid_s1 && $stable(word_s1)))
	`GBV_ASSERT_NEVER(a_ready_low_empty, clk, arst_n, !in_ch.ready && !valid_s1)

endmodule
`default_nettype wire

// ----- sim/tb_gb18030_stream_validator.sv -----
// Self-checking testbench for the GB18030 stream validator: random and directed strings.
`timescale 1ns / 1ps

module tb_gb18030_stream_validator;

	typedef enum {V_MATCH, V_WRONG, V_NONE} verdict_t;
	typedef enum {ST_CLEAN, ST_LONE_LEAD, ST_CUT_FOUR, ST_FLAWED, ST_NOISE} str_style_t;
	typedef enum {CH_ASCII, CH_TWO, CH_FOUR} char_kind_t;

	class gb_verdict_board_t;
		gbv_pkg::phase_t ph;
		logic [7:0]      lead;
		logic            bad;
		logic            verdict_q[$];

		function new();
			clear_string();
		endfunction

		function void clear_string();
			ph   = gbv_pkg::PH_LEAD;
			lead = 8'h00;
			bad  = 1'b0;
		endfunction

		static function logic numeral(logic [7:0] b);
			return b >= 8'h30 && b <= 8'h39;
		endfunction

		static function logic trail_fits(logic [7:0] l, logic [7:0] t);
			logic from_40;
			from_40 = t >= 8'h40 && t != 8'h7F;
			if ((l == 8'hA2 && t == 8'hE3) ||
				(l == 8'hA6 && ((t >= 8'hD9 && t <= 8'hDF) || t == 8'hF3)))
				return 1'b1;
			if (l <= 8'hA0 || (l >= 8'hB0 && l <= 8'hF7))
				return from_40 && t <= 8'hFE;
			if (l <= 8'hA7)
				return t >= 8'hA1 && t <= 8'hFE;
			if (l <= 8'hA9)
				return from_40 && t <= 8'hEF;
			return from_40 && t <= 8'hA0;
		endfunction

		function void note_word(logic [7:0] b, logic last);
			if (!bad) begin
				case (ph)
					gbv_pkg::PH_LEAD: begin
						if (b == 8'h80 || b == 8'hFF) begin
							bad = 1'b1;
						end else if (b > 8'h80) begin
							lead = b;
							ph   = gbv_pkg::PH_TRAIL;
						end
					end
					gbv_pkg::PH_TRAIL: begin
						if (numeral(b)) begin
							ph = gbv_pkg::PH_THIRD;
						end else begin
							if (!trail_fits(lead, b))
								bad = 1'b1;
							ph = gbv_pkg::PH_LEAD;
						end
					end
					gbv_pkg::PH_THIRD: begin
						if (b < 8'h81 || b == 8'hFF)
							bad = 1'b1;
						ph = gbv_pkg::PH_FOURTH;
					end
					default: begin
						if (!numeral(b) ||
							!((lead >= 8'h81 && lead <= 8'h84) ||
							(lead >= 8'h90 && lead <= 8'hE3)))
							bad = 1'b1;
						ph = gbv_pkg::PH_LEAD;
					end
				endcase
			end
			if (last) begin
				verdict_q.push_back(!bad &&
					(ph == gbv_pkg::PH_LEAD || ph == gbv_pkg::PH_TRAIL));
				clear_string();
			end
		endfunction

		function verdict_t check_verdict(logic got, output logic want);
			if (verdict_q.size() == 0) begin
				want = 1'b0;
				return V_NONE;
			end
			want = verdict_q.pop_front();
			return (got === want) ? V_MATCH : V_WRONG;
		endfunction

		function int pending();
			return verdict_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	gbv_byte_if   in_ch();
	gbv_result_if out_ch();

	gb18030_stream_validator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	gb_verdict_board_t board = new();

	int         errors;
	int         sent_count;
	int         tx_gap_pct;
	bit         calm;
	bit         held_long;
	logic [7:0] text_q[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("== FAIL ==");
		$finish;
	end

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		errors++;
	endtask

	always @(posedge clk) begin
		logic     want;
		verdict_t v;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				board.note_word(in_ch.data_byte, in_ch.is_last);
			if (out_ch.valid && out_ch.ready) begin
				v = board.check_verdict(out_ch.is_valid, want);
				if (v == V_NONE)
					report($sformatf("verdict %0b with no string pending", out_ch.is_valid));
				else if (v == V_WRONG)
					report($sformatf("is_valid %0b, expected %0b", out_ch.is_valid, want));
			end
		end
	end

	// verdict receiver: random stalls, one long hold-off to back up the input
	initial begin
		int cyc;
		int rx_pct;
		cyc = 0;
		rx_pct = 0;
		out_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 50 == 0)
				rx_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
			if (!held_long && !calm && sent_count >= 400) begin
				held_long = 1'b1;
				out_ch.ready = 1'b0;
				repeat (500) @(negedge clk);
			end
			if (!calm && $urandom_range(0, 99) < rx_pct) begin
				out_ch.ready = 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end
			out_ch.ready = 1'b1;
		end
	end

	task automatic send_word(input logic [7:0] b, input logic last);
		if (!calm && $urandom_range(0, 99) < tx_gap_pct) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_ch.valid     = 1'b1;
		in_ch.data_byte = b;
		in_ch.is_last   = last;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
		sent_count++;
	endtask

	task automatic send_text();
		foreach (text_q[i])
			send_word(text_q[i], i == text_q.size() - 1);
		text_q.delete();
	endtask

	function automatic logic [7:0] any_digit();
		return 8'h30 + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] four_lead();
		if ($urandom_range(0, 1))
			return 8'($urandom_range(8'h81, 8'h84));
		return 8'($urandom_range(8'h90, 8'hE3));
	endfunction

	task automatic add_two(input logic good);
		logic [7:0] l;
		logic [7:0] t;
		logic [7:0] edge_leads[11];
		edge_leads = '{8'hA0, 8'hA1, 8'hA2, 8'hA6, 8'hA7, 8'hA8, 8'hA9, 8'hAA,
			8'hB0, 8'hF7, 8'hF8};
		do begin
			if ($urandom_range(0, 3) == 0)
				l = edge_leads[$urandom_range(0, 10)];
			else
				l = 8'($urandom_range(8'h81, 8'hFE));
			t = good ? 8'($urandom_range(8'h40, 8'hFE)) : 8'($urandom_range(0, 255));
		end while (gb_verdict_board_t::trail_fits(l, t) != good ||
			gb_verdict_board_t::numeral(t));
		text_q.push_back(l);
		text_q.push_back(t);
	endtask

	task automatic add_four(input logic good);
		logic [7:0] l;
		logic [7:0] t3;
		logic [7:0] d4;
		l  = four_lead();
		t3 = 8'($urandom_range(8'h81, 8'hFE));
		d4 = any_digit();
		if (!good) begin
			case ($urandom_range(0, 2))
				0: l = $urandom_range(0, 1) ? 8'($urandom_range(8'h85, 8'h8F))
					: 8'($urandom_range(8'hE4, 8'hFE));
				1: t3 = $urandom_range(0, 1) ? 8'($urandom_range(0, 8'h80)) : 8'hFF;
				default: begin
					do d4 = 8'($urandom_range(0, 255));
					while (gb_verdict_board_t::numeral(d4));
				end
			endcase
		end
		text_q.push_back(l);
		text_q.push_back(any_digit());
		text_q.push_back(t3);
		text_q.push_back(d4);
	endtask

	task automatic add_char(input logic good);
		char_kind_t k;
		int r;
		r = $urandom_range(0, 99);
		k = (r < 40) ? CH_ASCII : (r < 75) ? CH_TWO : CH_FOUR;
		if (!good && k == CH_ASCII)
			text_q.push_back($urandom_range(0, 1) ? 8'h80 : 8'hFF);
		else if (k == CH_ASCII)
			text_q.push_back(8'($urandom_range(0, 8'h7F)));
		else if (k == CH_TWO)
			add_two(good);
		else
			add_four(good);
	endtask

	task automatic make_string();
		str_style_t style;
		int n;
		int flaw_at;
		int r;
		r = $urandom_range(0, 99);
		style = (r < 60) ? ST_CLEAN : (r < 70) ? ST_LONE_LEAD : (r < 78) ? ST_CUT_FOUR :
			(r < 90) ? ST_FLAWED : ST_NOISE;
		n = $urandom_range(1, 6);
		flaw_at = $urandom_range(0, n - 1);
		if (style == ST_NOISE) begin
			repeat ($urandom_range(1, 8))
				text_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			for (int i = 0; i < n; i++)
				add_char(!(style == ST_FLAWED && i == flaw_at));
			if (style == ST_LONE_LEAD) begin
				text_q.push_back(8'($urandom_range(8'h81, 8'hFE)));
			end else if (style == ST_CUT_FOUR) begin
				text_q.push_back(four_lead());
				text_q.push_back(any_digit());
				if ($urandom_range(0, 1))
					text_q.push_back(8'($urandom_range(8'h81, 8'hFE)));
			end
		end
	endtask

	initial begin
		int drain;
		errors          = 0;
		sent_count      = 0;
		tx_gap_pct      = 0;
		calm            = 1'b0;
		held_long       = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.data_byte = 8'h00;
		in_ch.is_last   = 1'b0;
		arst_n          = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		text_q = '{8'h00};                      send_text();
		text_q = '{8'h7F};                      send_text();
		text_q = '{8'h80};                      send_text();
		text_q = '{8'hFF};                      send_text();
		text_q = '{8'hFE};                      send_text();
		text_q = '{8'hA2, 8'hE3};               send_text();
		text_q = '{8'hA6, 8'hD9};               send_text();
		text_q = '{8'hA6, 8'hF3};               send_text();
		text_q = '{8'h81, 8'h7F};               send_text();
		text_q = '{8'h81, 8'h30, 8'h81, 8'h30}; send_text();
		text_q = '{8'hE3, 8'h39, 8'hFE, 8'h39}; send_text();
		text_q = '{8'h85, 8'h30, 8'h81, 8'h30}; send_text();
		text_q = '{8'h81, 8'h30};               send_text();
		// failure is sticky: a good ASCII byte after it changes nothing
		text_q = '{8'h80, 8'h41};               send_text();

		while (sent_count < 1700) begin
			case ($urandom_range(0, 3))
				0, 1: tx_gap_pct = 0;
				2: tx_gap_pct = 15;
				default: tx_gap_pct = 40;
			endcase
			if (sent_count >= 1500)
				calm = 1'b1;
			make_string();
			send_text();
		end
		in_ch.valid   = 1'b0;
		in_ch.is_last = 1'b0;

		drain = 0;
		while (board.pending() != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (10) @(posedge clk);
		if (board.pending() != 0)
			report($sformatf("%0d verdicts never arrived", board.pending()));
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
